@@ hw/rtl/averaged_level_bar_gauge_assert.svh @@
// Assertion macros shared by the gauge's checker.
`ifndef AVERAGED_LEVEL_BAR_GAUGE_ASSERT_SVH
`define AVERAGED_LEVEL_BAR_GAUGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ALBG_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALBG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/albg_pkg.sv @@
// Shared types, constants and helper functions for the averaged level bar gauge.
package albg_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int LEVEL_W         = 4;
  localparam int GAUGE_POSITIONS = 9;
  localparam int THRESH_COUNT    = 8;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [GAUGE_POSITIONS-1:0] mask_t;

  // Configuration register indexes, in threshold test order.
  typedef enum logic [2:0] {
    REG_THRESH_EMPTY = 3'd0,
    REG_THRESH_ONE   = 3'd1,
    REG_THRESH_TWO   = 3'd2,
    REG_THRESH_THREE = 3'd3,
    REG_THRESH_FOUR  = 3'd4,
    REG_THRESH_FIVE  = 3'd5,
    REG_THRESH_SIX   = 3'd6,
    REG_THRESH_SEVEN = 3'd7
  } reg_index_t;

  localparam level_t LEVEL_EMPTY = 4'd0;
  localparam level_t LEVEL_FULL  = 4'd8;

  function automatic sample_t thresh_reset(reg_index_t idx);
    sample_t value;
    case (idx)
      REG_THRESH_EMPTY: value = 10'd710;
      REG_THRESH_ONE:   value = 10'd670;
      REG_THRESH_TWO:   value = 10'd628;
      REG_THRESH_THREE: value = 10'd586;
      REG_THRESH_FOUR:  value = 10'd536;
      REG_THRESH_FIVE:  value = 10'd473;
      REG_THRESH_SIX:   value = 10'd374;
      REG_THRESH_SEVEN: value = 10'd120;
      default:          value = 10'd0;
    endcase
    return value;
  endfunction

  // Positions 0 through the level are lit; nothing is lit when empty.
  function automatic mask_t mask_of(level_t lvl);
    mask_t m;
    for (int i = 0; i < GAUGE_POSITIONS; i++) begin
      m[i] = (lvl != LEVEL_EMPTY) && (LEVEL_W'(i) <= lvl);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/albg_cell.sv @@
// One sample cell of the averaging delay line.
module albg_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  albg_pkg::sample_t din,
  output albg_pkg::sample_t dout
);

  albg_pkg::sample_t sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift) begin
      sample <= din;
    end
  end

  assign dout = sample;

endmodule

@@ hw/rtl/albg_level.sv @@
// Threshold compare, level quantizer, flash flag and result register.
module albg_level #(
  parameter int AVG_LENGTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_write,
  input  logic [2:0]                                  cfg_index,
  input  albg_pkg::sample_t                           cfg_data,
  input  logic                                        load,
  input  logic [$clog2(AVG_LENGTH*1023+1)-1:0]        sum,
  output albg_pkg::level_t                            gauge_level,
  output albg_pkg::mask_t                             lit_mask,
  output logic                                        empty_flash
);

  localparam int SCALE_W = $clog2(AVG_LENGTH*1024+1);
  localparam logic [SCALE_W-1:0] LEN_S = SCALE_W'(AVG_LENGTH);

  // Thresholds are kept as (t + 1) * AVG_LENGTH, so that avg > t
  // becomes sum >= scaled threshold and no division is needed.
  logic [SCALE_W-1:0] thr_scaled [albg_pkg::THRESH_COUNT];
  logic [albg_pkg::THRESH_COUNT-1:0] hit;
  albg_pkg::level_t level_next;
  logic flash_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < albg_pkg::THRESH_COUNT; k++) begin
        thr_scaled[k] <= (SCALE_W'(albg_pkg::thresh_reset(albg_pkg::reg_index_t'(k)))
                          + SCALE_W'(1)) * LEN_S;
      end
    end else if (cfg_write) begin
      thr_scaled[cfg_index] <= (SCALE_W'(cfg_data) + SCALE_W'(1)) * LEN_S;
    end
  end

  always_comb begin
    for (int k = 0; k < albg_pkg::THRESH_COUNT; k++) begin
      hit[k] = SCALE_W'(sum) >= thr_scaled[k];
    end
  end

  // The first threshold exceeded in test order wins.
  always_comb begin
    level_next = albg_pkg::LEVEL_FULL;
    for (int k = albg_pkg::THRESH_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        level_next = albg_pkg::LEVEL_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_on <= 1'b1;
    end else if (load) begin
      if (level_next == albg_pkg::LEVEL_EMPTY) begin
        flash_on <= !flash_on;
      end else begin
        flash_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gauge_level <= level_next;
      lit_mask    <= albg_pkg::mask_of(level_next);
      empty_flash <= (level_next == albg_pkg::LEVEL_EMPTY) && !flash_on;
    end
  end

endmodule

@@ hw/rtl/averaged_level_bar_gauge.sv @@
// Top level of the averaged level bar gauge.
// Averaged level bar gauge. Each sample beat is shifted into a row of
// AVG_LENGTH sample cells, and a running sum adds the new sample and drops
// the one that falls off the end of the row, so the sum always covers the
// last AVG_LENGTH samples (the cells reset to zero, so early averages read
// low). The sum is compared against eight thresholds, each held pre-scaled
// by AVG_LENGTH, and the first one that the average exceeds gives the level;
// none exceeded gives level 8. Levels 1 to 8 light positions 0 through the
// level in lit_mask. Level 0 toggles the flash flag and shows it on
// empty_flash; any nonzero level clears the flag. The block takes one sample
// beat per clock while sample_ready is high and returns one result beat per
// sample: the edge that accepts a sample updates the running sum register,
// and the threshold compare of that sum is loaded into the result register
// when that register is empty or being taken. sample_ready drops only while
// a finished result is held for result_ready. Threshold writes on the cfg
// port take effect at once and belong only to idle periods. No clearing pass
// is needed after reset.
module averaged_level_bar_gauge #(
  parameter int AVG_LENGTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  albg_pkg::sample_t cfg_data,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  albg_pkg::sample_t sample_value,
  output logic              result_valid,
  input  logic              result_ready,
  output albg_pkg::level_t  gauge_level,
  output albg_pkg::mask_t   lit_mask,
  output logic              empty_flash
);

  localparam int SUM_W = $clog2(AVG_LENGTH*1023+1);

  albg_pkg::sample_t tap [AVG_LENGTH+1];
  logic [SUM_W-1:0]  running_sum;
  logic              sum_valid;
  logic              advance;
  logic              accept;
  logic              load;

  // The result register moves when it is empty or being taken, and the
  // sum stage moves into it at the same time.
  assign advance      = !result_valid || result_ready;
  assign sample_ready = !sum_valid || advance;
  assign accept       = sample_valid && sample_ready;
  assign load         = sum_valid && advance;

  assign tap[0] = sample_value;

  // The delay line: cell i holds the sample taken i+1 beats ago, and the
  // last cell holds the one about to leave the window.
  for (genvar i = 0; i < AVG_LENGTH; i++) begin : g_cell
    albg_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .din   (tap[i]),
      .dout  (tap[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (accept) begin
      running_sum <= running_sum + SUM_W'(sample_value) - SUM_W'(tap[AVG_LENGTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (accept) begin
      sum_valid <= 1'b1;
    end else if (load) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  albg_level #(
    .AVG_LENGTH (AVG_LENGTH)
  ) u_level (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load        (load),
    .sum         (running_sum),
    .gauge_level (gauge_level),
    .lit_mask    (lit_mask),
    .empty_flash (empty_flash)
  );

endmodule

@@ hw/rtl/albg_checker.sv @@
// Port-level checker for the averaged level bar gauge, with its bind.
`include "averaged_level_bar_gauge_assert.svh"

module albg_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input albg_pkg::level_t  gauge_level,
  input albg_pkg::mask_t   lit_mask,
  input logic              empty_flash
);

  `ALBG_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(gauge_level) && $stable(lit_mask) && $stable(empty_flash), "result beat changed while stalled")
  `ALBG_ASSERT_NOW(a_mask_empty, clk, rst, result_valid, (gauge_level == albg_pkg::LEVEL_EMPTY) == (lit_mask == 9'd0), "lit mask disagrees with empty level")
  `ALBG_ASSERT_NOW(a_mask_solid, clk, rst, result_valid, (lit_mask & (lit_mask + 9'd1)) == 9'd0, "lit mask is not a solid bar")
  `ALBG_ASSERT_NOW(a_flash_empty, clk, rst, result_valid && (gauge_level != albg_pkg::LEVEL_EMPTY), !empty_flash, "flash shown on a nonzero level")

endmodule

bind averaged_level_bar_gauge albg_checker u_checker (.*);
